@@ hw/rtl/bqd_pkg.sv @@
// package: payload types, format codes and constants for the block dequantizer
package bqd_pkg;

   localparam int BLOCK_ELEMENTS_DEF = 32;

   typedef enum logic [2:0] {
      FMT_F32  = 3'd0,
      FMT_F16  = 3'd1,
      FMT_Q8_0 = 3'd2,
      FMT_Q4_0 = 3'd3
   } fmt_type;

   localparam logic [31:0] QNAN_DEFAULT = 32'h7FC0_0000;
   localparam logic [3:0]  NIBBLE_MASK  = 4'hF;
   localparam logic [3:0]  NIBBLE_BIAS  = 4'd8;

   typedef struct packed {
      logic [31:0] raw_word;
      logic [15:0] block_scale;
      logic [4:0]  element_pos;
      logic        last_in_row;
   } req_type;

   typedef struct packed {
      logic [31:0] value_bits;
      logic        unsupported;
      logic        row_end;
   } rsp_type;

   // index of the leading one in an 18-bit value
   function automatic logic [4:0] lead_one(input logic [17:0] v);
      logic [4:0] r;
      r = 5'd0;
      for (int i = 0; i < 18; i++) begin
         if (v[i]) r = 5'(i);
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/block_quant_dequantizer_top.sv @@
// top level of the block-quantized weight dequantizer
// usage:
//   write the source format on csr_wr_en/csr_wr_data while idle
//   (0 f32, 1 f16, 2 q8_0, 3 q4_0, other values give zero and flag unsupported)
//   present one element on req_data with start high; busy is always low,
//   so one transaction is taken every cycle
//   the element is registered, converted by one pass of combinational logic
//   (one 8x11 multiply and leading-one search) and registered again
//   the start flag passes through in_vld_ff and then out_vld_ff, so rsp_valid
//   rises together with the registered result on rsp_data
//   throughput: one element per cycle
//   the receiver cannot stall; each result shows for one cycle only
//   reset clears the pipeline valid bits and sets the format to f32
module block_quant_dequantizer_top
   import bqd_pkg::*;
#(
   parameter int BLOCK_ELEMENTS = BLOCK_ELEMENTS_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_wr_data
);

   logic [2:0] fmt_ff;
   logic       in_vld_ff;
   req_type    in_ff;
   logic       out_vld_ff;
   rsp_type    out_ff;
   rsp_type    conv_in;
   req_type    req_in;

   always_comb begin
      req_in             = req_data;
      req_in.element_pos = 5'(req_data.element_pos % BLOCK_ELEMENTS);
   end

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff     <= FMT_F32;
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) fmt_ff <= csr_wr_data;
         in_vld_ff  <= start;
         out_vld_ff <= in_vld_ff;
      end
      in_ff  <= req_in;
      out_ff <= conv_in;
   end

   bqd_convert u_convert (
      .fmt (fmt_ff),
      .req (in_ff),
      .rsp (conv_in)
   );

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   a_lat: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff |=> rsp_valid) else $error("lost transaction");
   a_unsup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.unsupported |-> rsp_data.value_bits == 32'd0)
      else $error("unsupported nonzero");
   a_row: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff |=> rsp_data.row_end == $past(in_ff.last_in_row))
      else $error("row end lost");

endmodule

@@ hw/rtl/bqd_convert.sv @@
// combinational conversion of one element to single precision
module bqd_convert
   import bqd_pkg::*;
(
   input  logic [2:0] fmt,
   input  req_type    req,
   output rsp_type    rsp
);

   logic [15:0] h;
   logic [4:0]  hex;
   logic [9:0]  hman;
   logic [31:0] h2s;
   logic [4:0]  hlead;
   logic [9:0]  hnorm;
   logic [7:0]  q;
   logic [7:0]  qa;
   logic        qs;
   logic [3:0]  nib;
   logic [4:0]  sex;
   logic [9:0]  sman;
   logic        ssg;
   logic [10:0] m;
   logic [17:0] p;
   logic [4:0]  t;
   logic [8:0]  ebias;
   logic [8:0]  eout;
   logic [31:0] mulv;
   logic [31:0] snan;
   logic [17:0] pshift;
   logic        sign;

   always_comb begin
      h     = req.raw_word[15:0];
      hex   = h[14:10];
      hman  = h[9:0];
      hlead = lead_one({8'd0, hman});
      hnorm = 10'(hman << (5'd10 - hlead));
      if (hex == 5'h1F) h2s = {h[15], 8'hFF, hman, 13'd0};
      else if (hex != 5'd0) h2s = {h[15], 8'(hex) + 8'd112, hman, 13'd0};
      else if (hman == 10'd0) h2s = {h[15], 31'd0};
      else h2s = {h[15], 8'(hlead) + 8'd103, hnorm, 13'd0};

      nib = req.element_pos[0] ? req.raw_word[7:4] : (req.raw_word[3:0] & NIBBLE_MASK);
      if (fmt == FMT_Q4_0) q = {4'd0, nib} - {4'd0, NIBBLE_BIAS};
      else q = req.raw_word[7:0];
      qs = q[7];
      qa = qs ? 8'(-q) : q;

      ssg  = req.block_scale[15];
      sex  = req.block_scale[14:10];
      sman = req.block_scale[9:0];
      sign = ssg ^ qs;
      snan = {ssg, 8'hFF, 1'b1, sman[8:0], 13'd0};
      if (sex != 5'd0) begin
         m     = {1'b1, sman};
         ebias = 9'(sex) + 9'd102;
      end else begin
         m     = {1'b0, sman};
         ebias = 9'd103;
      end
      p      = 18'(qa) * 18'(m);
      t      = lead_one(p);
      eout   = 9'(t) + ebias;
      pshift = 18'(p << (5'd17 - t));
      if (sex == 5'h1F) begin
         if (sman != 10'd0) mulv = snan;
         else if (qa == 8'd0) mulv = QNAN_DEFAULT;
         else mulv = {sign, 8'hFF, 23'd0};
      end else if (p == 18'd0) mulv = {sign, 31'd0};
      else mulv = {sign, eout[7:0], pshift[16:0], 6'd0};

      rsp.row_end     = req.last_in_row;
      rsp.unsupported = 1'b0;
      unique case (fmt)
         FMT_F32:  rsp.value_bits = req.raw_word;
         FMT_F16:  rsp.value_bits = h2s;
         FMT_Q8_0: rsp.value_bits = mulv;
         FMT_Q4_0: rsp.value_bits = mulv;
         default: begin
            rsp.value_bits  = 32'd0;
            rsp.unsupported = 1'b1;
         end
      endcase
   end

endmodule

@@ tb/block_quant_dequantizer_checker.sv @@
// checker: predicts each dequantized element and compares it with the block output
module block_quant_dequantizer_checker
   import bqd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_wr_data,
   output int         fail_count,
   output int         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [2:0] src_format;
   rsp_type    expected_values[$];

   function automatic logic [31:0] widen_half(input logic [15:0] h);
      logic [31:0] sgn;
      logic [4:0]  ex;
      logic [9:0]  man;
      logic [7:0]  e;
      sgn = {h[15], 31'b0};
      ex  = h[14:10];
      man = h[9:0];
      if (ex == 5'h1F) return sgn | 32'h7F80_0000 | ({22'b0, man} << 13);
      if (ex != 0) return sgn | ({24'b0, 8'(ex) + 8'd112} << 23) | ({22'b0, man} << 13);
      if (man == 0) return sgn;
      e = 8'd113;
      while (!man[9]) begin
         man = man << 1;
         e = e - 1;
      end
      // after shifting, the implicit bit sits in the top bit of man; one more shift drops it
      man = man << 1;
      e = e - 1;
      return sgn | ({24'b0, e} << 23) | ({22'b0, man} << 13);
   endfunction

   function automatic logic [31:0] scaled_product(input int q, input logic [15:0] h);
      logic [31:0] sgn, m, p;
      logic [4:0]  ex;
      logic [9:0]  man;
      int          e, t, qa;
      ex  = h[14:10];
      man = h[9:0];
      sgn = {h[15] ^ (q < 0), 31'b0};
      qa  = (q < 0) ? -q : q;
      if (ex == 5'h1F) begin
         if (man != 0) return widen_half(h) | 32'h0040_0000;
         if (qa == 0) return QNAN_DEFAULT;
         return sgn | 32'h7F80_0000;
      end
      if (ex != 0) begin
         m = {21'b0, 1'b1, man};
         e = int'(ex) - 25;
      end else begin
         m = {22'b0, man};
         e = -24;
      end
      p = qa * m;
      if (p == 0) return sgn;
      t = 0;
      while ((p >> (t + 1)) != 0) t++;
      return sgn | (32'(t + e + 127) << 23) | ((p << (23 - t)) & 32'h007F_FFFF);
   endfunction

   function automatic rsp_type dequantize(input req_type r, input logic [2:0] f);
      rsp_type    o;
      logic [3:0] nib;
      o.value_bits  = 0;
      o.unsupported = 0;
      o.row_end     = r.last_in_row;
      case (f)
         FMT_F32:  o.value_bits = r.raw_word;
         FMT_F16:  o.value_bits = widen_half(r.raw_word[15:0]);
         FMT_Q8_0: o.value_bits = scaled_product(int'($signed(r.raw_word[7:0])),
                                                 r.block_scale);
         FMT_Q4_0: begin
            nib = r.element_pos[0] ? r.raw_word[7:4] : r.raw_word[3:0];
            o.value_bits = scaled_product(int'(nib) - 8, r.block_scale);
         end
         default:  o.unsupported = 1;
      endcase
      return o;
   endfunction

   assign pending_count = expected_values.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         src_format <= FMT_F32;
         fail_count <= 0;
         expected_values.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_values.size() == 0) begin
               $error("unexpected transaction: value_bits %h", rsp_data.value_bits);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_values.pop_front();
               if (want != rsp_data) begin
                  if (want.value_bits != rsp_data.value_bits)
                     $error("value_bits expected %h actual %h",
                            want.value_bits, rsp_data.value_bits);
                  if (want.unsupported != rsp_data.unsupported)
                     $error("unsupported expected %b actual %b",
                            want.unsupported, rsp_data.unsupported);
                  if (want.row_end != rsp_data.row_end)
                     $error("row_end expected %b actual %b",
                            want.row_end, rsp_data.row_end);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) expected_values.push_back(dequantize(req_data, src_format));
         if (csr_wr_en) src_format <= csr_wr_data;
      end
   end
endmodule

@@ tb/tb_block_quant_dequantizer_top.sv @@
// testbench top: drives elements and format settings, reports the verdict
module tb_block_quant_dequantizer_top;
   import bqd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock = 0;
   logic       reset = 1;
   logic       start = 0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_wr_en = 0;
   logic [2:0] csr_wr_data = 0;
   int         fail_count, pending_count;
   int         cycle_count = 0;
   logic       timed_out = 0;

   localparam int CYCLE_LIMIT = 200000;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   block_quant_dequantizer_top uut (.*);
   block_quant_dequantizer_checker chk (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT && !timed_out) begin
         timed_out <= 1;
         $display("** block_quant_dequantizer_top: FAILED **");
         $finish;
      end
   end

   task automatic set_format(input logic [2:0] f);
      wait (pending_count == 0);
      @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1;
      csr_wr_data <= f;
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   task automatic send_element(input req_type r, input int gap);
      req_data <= r;
      start    <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic logic [15:0] pick_scale();
      case ($urandom_range(0, 5))
         0: return {$urandom_range(0, 1) == 1, 5'h1F, 10'($urandom)};
         1: return {$urandom_range(0, 1) == 1, 5'h00, 10'($urandom)};
         2: return {$urandom_range(0, 1) == 1, 5'h1F, 10'h000};
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type random_element();
      req_type r;
      r.raw_word    = $urandom;
      if ($urandom_range(0, 7) == 0) r.raw_word[7:0] = 8'h00;
      if ($urandom_range(0, 7) == 0) r.raw_word[7:0] = 8'h88;
      r.block_scale = pick_scale();
      r.element_pos = 5'($urandom);
      r.last_in_row = ($urandom_range(0, 31) == 0);
      return r;
   endfunction

   task automatic directed_part();
      logic [15:0] scales[7];
      logic [31:0] words[3];
      scales = '{16'h3C00, 16'hFC00, 16'h7C00, 16'h7D01, 16'hFE00, 16'h0001, 16'h7BFF};
      words  = '{32'h0000_0080, 32'hFFFF_FF7F, 32'h0000_0008};
      for (int i = 0; i < 7; i++)
         send_element('{words[i % 3], scales[i], 5'(i), i[0]}, 0);
      send_element('{32'h0000_00F0, 16'h7C00, 5'd31, 1'b1}, 1);
      send_element('{32'hFFFF_FFFF, 16'hFFFF, 5'd0, 1'b0}, 0);
      send_element('{32'h0000_0000, 16'h0000, 5'd1, 1'b1}, 0);
      start <= 0;
   endtask

   initial begin
      logic [2:0] fmts[6];
      fmts = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd7, 3'd0};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // format f32 after reset
      directed_part();
      foreach (fmts[i]) begin
         set_format(fmts[i]);
         directed_part();
         send_element('{32'h0000_7E01, 16'h3C00, 5'd2, 1'b0}, 0);
         send_element('{32'h0000_0001, 16'h3C00, 5'd3, 1'b0}, 0);
         start <= 0;
      end
      for (int b = 0; b < 25; b++) begin
         set_format(($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                                : 3'($urandom_range(0, 3)));
         for (int i = 0; i < 50; i++)
            send_element(random_element(),
                         ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19));
         start <= 0;
      end
      wait (pending_count == 0);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("** block_quant_dequantizer_top: PASSED **");
      else
         $display("** block_quant_dequantizer_top: FAILED **");
      $finish;
   end
endmodule
